// ----- design/nnbs_pkg.sv -----
// ----------------------------------------------------------------------------
// nnbs_pkg
// Shared widths, codes and defaults for the nearest-neighbor binarize scaler.
// ----------------------------------------------------------------------------
package nnbs_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W     = 8;
    localparam int PIXEL_W     = 8;
    localparam int LOAD_ADDR_W = 16;
    localparam int SIZE_W      = 9;
    localparam int REG_IDX_W   = 2;

    // A scaled coordinate is an 8-bit coordinate times a 9-bit size.
    localparam int PROD_W      = COORD_W + SIZE_W;
    // One restoring step per product bit.
    localparam int DIV_STEPS   = PROD_W;
    // Row times width plus column.
    localparam int SUM_W       = 2 * SIZE_W + 1;

    // Defaults for the top-level parameters.
    localparam int MAX_SOURCE_PIXELS_DEF = 65536;
    localparam int MAX_SIDE_DEF          = 256;

    // Binarization constants.
    localparam logic [PIXEL_W-1:0] THRESHOLD = 8'd128;
    localparam logic [PIXEL_W-1:0] MARK_ON   = 8'd255;
    localparam logic [PIXEL_W-1:0] MARK_OFF  = 8'd0;

    // Input beat kinds.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

    // Register reset values.
    localparam logic [SIZE_W-1:0] SOURCE_WIDTH_RST  = 9'd256;
    localparam logic [SIZE_W-1:0] SOURCE_HEIGHT_RST = 9'd256;
    localparam logic [SIZE_W-1:0] TARGET_WIDTH_RST  = 9'd64;
    localparam logic [SIZE_W-1:0] TARGET_HEIGHT_RST = 9'd64;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_ADDR = 5'b00100,
        ST_READ = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

// ----- design/nearest_neighbor_binarize_scaler.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_binarize_scaler
// Source frame store with nearest-neighbor lookup and binary threshold.
// ----------------------------------------------------------------------------
// A load beat writes one source pixel into the frame memory; it produces no
// result. A fetch beat maps the target coordinate to a source pixel with two
// restoring dividers that run side by side, one quotient bit per cycle, then
// forms the raster address, reads the frame memory and returns 255 when the
// pixel exceeds 128, else 0. A fetch passes through an accept step, 17
// divider steps, an address step, a memory read and a result step, and the
// result register loads in the result step. A coordinate outside the target
// size skips the dividers and returns 0 with out_of_range set; it goes from
// the accept step straight to the result step. A finished fetch waits in the
// result step, and holds off the input, while an earlier result still waits
// on m_ready. New beats are accepted while a finished result still waits on
// m_ready.
// Configuration must only be written while no fetch is in flight.
module nearest_neighbor_binarize_scaler #(
    parameter int MAX_SOURCE_PIXELS = nnbs_pkg::MAX_SOURCE_PIXELS_DEF,
    parameter int MAX_SIDE          = nnbs_pkg::MAX_SIDE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration write port
    input  logic                              cfg_we,
    input  logic [nnbs_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [nnbs_pkg::SIZE_W-1:0]       cfg_wdata,

    // Input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [nnbs_pkg::LOAD_ADDR_W-1:0]  s_load_address,
    input  logic [nnbs_pkg::PIXEL_W-1:0]      s_load_pixel,
    input  logic [nnbs_pkg::COORD_W-1:0]      s_target_x,
    input  logic [nnbs_pkg::COORD_W-1:0]      s_target_y,

    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [nnbs_pkg::PIXEL_W-1:0]      m_mark_value,
    output logic                              m_out_of_range
);

    localparam int SIZE_W   = nnbs_pkg::SIZE_W;
    localparam int PROD_W   = nnbs_pkg::PROD_W;
    localparam int PIXEL_W  = nnbs_pkg::PIXEL_W;
    localparam int AW       = $clog2(MAX_SOURCE_PIXELS);
    localparam int MAP_W    = (AW > nnbs_pkg::SUM_W) ? AW : nnbs_pkg::SUM_W;
    localparam int CNT_W    = $clog2(nnbs_pkg::DIV_STEPS + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] source_width_reg;
    logic [SIZE_W-1:0] source_height_reg;
    logic [SIZE_W-1:0] target_width_reg;
    logic [SIZE_W-1:0] target_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_width_reg  <= nnbs_pkg::SOURCE_WIDTH_RST;
            source_height_reg <= nnbs_pkg::SOURCE_HEIGHT_RST;
            target_width_reg  <= nnbs_pkg::TARGET_WIDTH_RST;
            target_height_reg <= nnbs_pkg::TARGET_HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                nnbs_pkg::REG_SOURCE_WIDTH:  source_width_reg  <= cfg_wdata;
                nnbs_pkg::REG_SOURCE_HEIGHT: source_height_reg <= cfg_wdata;
                nnbs_pkg::REG_TARGET_WIDTH:  target_width_reg  <= cfg_wdata;
                nnbs_pkg::REG_TARGET_HEIGHT: target_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sizes in use: zero counts as one, anything above MAX_SIDE saturates.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
        logic [SIZE_W-1:0] v;
        v = raw;
        if (32'(raw) > 32'(MAX_SIDE)) begin
            v = SIZE_W'(MAX_SIDE);
        end
        if (raw == '0) begin
            v = SIZE_W'(1);
        end
        return v;
    endfunction

    logic [SIZE_W-1:0] sw_eff;
    logic [SIZE_W-1:0] sh_eff;
    logic [SIZE_W-1:0] tw_eff;
    logic [SIZE_W-1:0] th_eff;

    assign sw_eff = eff_size(source_width_reg);
    assign sh_eff = eff_size(source_height_reg);
    assign tw_eff = eff_size(target_width_reg);
    assign th_eff = eff_size(target_height_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    nnbs_pkg::state_t state_reg;
    nnbs_pkg::state_t state_next;

    logic [CNT_W-1:0]  div_count_reg;
    logic [PROD_W-1:0] num_x_reg;
    logic [PROD_W-1:0] num_y_reg;
    logic [SIZE_W-1:0] rem_x_reg;
    logic [SIZE_W-1:0] rem_y_reg;
    logic [MAP_W-1:0]  addr_reg;
    logic              hit_reg;
    logic              oor_reg;
    logic [PIXEL_W-1:0] rd_data_reg;

    logic m_valid_reg;
    logic [PIXEL_W-1:0] m_mark_value_reg;
    logic m_out_of_range_reg;

    logic s_accept;
    logic fetch_accept;
    logic load_accept;
    logic coord_oor;
    logic result_load;

    assign s_ready      = (state_reg == nnbs_pkg::ST_IDLE);
    assign s_accept     = s_valid && s_ready;
    assign fetch_accept = s_accept && (s_action == nnbs_pkg::ACT_FETCH);
    assign load_accept  = s_accept && (s_action == nnbs_pkg::ACT_LOAD);
    assign coord_oor    = ({1'b0, s_target_x} >= tw_eff) || ({1'b0, s_target_y} >= th_eff);

    // The result register takes a new beat when it is empty or being drained.
    assign result_load  = (state_reg == nnbs_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            nnbs_pkg::ST_IDLE: begin
                if (fetch_accept) begin
                    state_next = coord_oor ? nnbs_pkg::ST_DONE : nnbs_pkg::ST_DIV;
                end
            end
            nnbs_pkg::ST_DIV: begin
                if (div_count_reg == '0) begin
                    state_next = nnbs_pkg::ST_ADDR;
                end
            end
            nnbs_pkg::ST_ADDR: state_next = nnbs_pkg::ST_READ;
            nnbs_pkg::ST_READ: state_next = nnbs_pkg::ST_DONE;
            nnbs_pkg::ST_DONE: begin
                if (result_load) begin
                    state_next = nnbs_pkg::ST_IDLE;
                end
            end
            default: state_next = nnbs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nnbs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Two restoring dividers, one quotient bit per cycle each.
    // The dividend register shifts left and collects quotient bits.
    // ------------------------------------------------------------------
    logic [SIZE_W:0]   shift_x;
    logic [SIZE_W:0]   shift_y;
    logic              ge_x;
    logic              ge_y;
    logic [SIZE_W:0]   diff_x;
    logic [SIZE_W:0]   diff_y;

    assign shift_x = {rem_x_reg, num_x_reg[PROD_W-1]};
    assign shift_y = {rem_y_reg, num_y_reg[PROD_W-1]};
    assign ge_x    = shift_x >= {1'b0, tw_eff};
    assign ge_y    = shift_y >= {1'b0, th_eff};
    assign diff_x  = shift_x - {1'b0, tw_eff};
    assign diff_y  = shift_y - {1'b0, th_eff};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_count_reg <= '0;
        end else if (state_reg == nnbs_pkg::ST_IDLE) begin
            div_count_reg <= CNT_W'(nnbs_pkg::DIV_STEPS - 1);
        end else if (state_reg == nnbs_pkg::ST_DIV && div_count_reg != '0) begin
            div_count_reg <= div_count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (fetch_accept) begin
            num_x_reg <= PROD_W'(s_target_x) * PROD_W'(sw_eff);
            num_y_reg <= PROD_W'(s_target_y) * PROD_W'(sh_eff);
            rem_x_reg <= '0;
            rem_y_reg <= '0;
        end else if (state_reg == nnbs_pkg::ST_DIV) begin
            num_x_reg <= {num_x_reg[PROD_W-2:0], ge_x};
            num_y_reg <= {num_y_reg[PROD_W-2:0], ge_y};
            rem_x_reg <= ge_x ? diff_x[SIZE_W-1:0] : shift_x[SIZE_W-1:0];
            rem_y_reg <= ge_y ? diff_y[SIZE_W-1:0] : shift_y[SIZE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Raster address: source row times source width plus source column.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (state_reg == nnbs_pkg::ST_ADDR) begin
            addr_reg <= MAP_W'(num_y_reg[SIZE_W-1:0] * sw_eff)
                      + MAP_W'(num_x_reg[SIZE_W-1:0]);
        end
    end

    // An out-of-range coordinate never reads the store; a mapped address
    // beyond the store reads as zero.
    always_ff @(posedge aclk) begin
        if (fetch_accept) begin
            oor_reg <= coord_oor;
            hit_reg <= 1'b0;
        end else if (state_reg == nnbs_pkg::ST_READ) begin
            hit_reg <= {1'b0, addr_reg} < (MAP_W + 1)'(MAX_SOURCE_PIXELS);
        end
    end

    // ------------------------------------------------------------------
    // Frame memory: written on a load beat, read in the read state.
    // ------------------------------------------------------------------
    logic [PIXEL_W-1:0] frame_mem [MAX_SOURCE_PIXELS];
    logic [31:0]        load_addr_ext;
    logic               load_in_store;

    assign load_addr_ext = 32'(s_load_address);
    assign load_in_store = load_addr_ext < 32'(MAX_SOURCE_PIXELS);

    always_ff @(posedge aclk) begin
        if (load_accept && load_in_store) begin
            frame_mem[load_addr_ext[AW-1:0]] <= s_load_pixel;
        end
        if (state_reg == nnbs_pkg::ST_READ) begin
            rd_data_reg <= frame_mem[addr_reg[AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_load) begin
            m_out_of_range_reg <= oor_reg;
            m_mark_value_reg   <= (hit_reg && (rd_data_reg > nnbs_pkg::THRESHOLD))
                                  ? nnbs_pkg::MARK_ON : nnbs_pkg::MARK_OFF;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mark_value   = m_mark_value_reg;
    assign m_out_of_range = m_out_of_range_reg;

`ifndef SYNTH
    // A delivered mark is always fully off or fully on.
    a_mark_binary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_mark_value == nnbs_pkg::MARK_OFF || m_mark_value == nnbs_pkg::MARK_ON))
        else $error("mark value is neither off nor on");

    // An out-of-range result never carries a set mark.
    a_oor_mark_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_of_range) |-> (m_mark_value == nnbs_pkg::MARK_OFF))
        else $error("out-of-range result with mark set");

    // After the dividers the source column lies inside the source width.
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nnbs_pkg::ST_ADDR) |-> (num_x_reg < PROD_W'(sw_eff)))
        else $error("mapped column beyond source width");

    // After the dividers the source row lies inside the source height.
    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nnbs_pkg::ST_ADDR) |-> (num_y_reg < PROD_W'(sh_eff)))
        else $error("mapped row beyond source height");

    // A fetch beat blocks the input until its result is formed.
    a_fetch_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        fetch_accept |=> !s_ready)
        else $error("input accepted while a fetch is in flight");
`endif

endmodule

// ----- tb/sv/nearest_neighbor_binarize_scaler_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_binarize_scaler_test
// Self-checking bench for the nearest-neighbor binarize scaler. A queue of
// load and fetch beats feeds a clocked driver. A shadow frame and shadow size
// registers predict each fetch result when the beat is accepted. A clocked
// monitor compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module nearest_neighbor_binarize_scaler_test;

    localparam int FRAME_DEPTH   = nnbs_pkg::MAX_SOURCE_PIXELS_DEF;
    localparam int SIDE_MAX      = nnbs_pkg::MAX_SIDE_DEF;
    localparam int COORD_W       = nnbs_pkg::COORD_W;
    localparam int PIXEL_W       = nnbs_pkg::PIXEL_W;
    localparam int ADDR_W        = nnbs_pkg::LOAD_ADDR_W;
    localparam int SIZE_W        = nnbs_pkg::SIZE_W;
    localparam int IDX_W         = nnbs_pkg::REG_IDX_W;
    localparam int SETTLE_CYCLES = 32;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_BEATS  = 75;

    typedef struct packed {
        logic               action;
        logic [ADDR_W-1:0]  load_address;
        logic [PIXEL_W-1:0] load_pixel;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
    } scaler_beat_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] mark_value;
        logic               out_of_range;
    } mark_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [IDX_W-1:0]   cfg_index = nnbs_pkg::REG_SOURCE_WIDTH;
    logic [SIZE_W-1:0]  cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_action = nnbs_pkg::ACT_LOAD;
    logic [ADDR_W-1:0]  s_load_address = '0;
    logic [PIXEL_W-1:0] s_load_pixel = '0;
    logic [COORD_W-1:0] s_target_x = '0;
    logic [COORD_W-1:0] s_target_y = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [PIXEL_W-1:0] m_mark_value;
    logic               m_out_of_range;

    // Shadow state of the block.
    logic [SIZE_W-1:0]  size_reg [0:3];
    logic [PIXEL_W-1:0] frame_shadow [0:FRAME_DEPTH-1];
    // Entries that the stimulus has loaded so far; fetches only map onto these.
    bit                 loaded_map [0:FRAME_DEPTH-1];

    scaler_beat_t pending_beats [$];
    mark_result_t awaited_marks [$];
    scaler_beat_t beat_on_bus;
    bit           beat_held = 1'b0;
    int           send_gap_pct = 0;
    int           recv_stall_pct = 0;
    int           phase_index = 0;
    int           mismatch_count = 0;
    int           quiet_cycles = 0;

    nearest_neighbor_binarize_scaler u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_load_address (s_load_address),
        .s_load_pixel   (s_load_pixel),
        .s_target_x     (s_target_x),
        .s_target_y     (s_target_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mark_value   (m_mark_value),
        .m_out_of_range (m_out_of_range)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Zero selects one pixel and anything above the largest side saturates.
    function automatic int clamp_side(logic [SIZE_W-1:0] raw);
        if (raw == '0) begin
            return 1;
        end
        if (int'(raw) > SIDE_MAX) begin
            return SIDE_MAX;
        end
        return int'(raw);
    endfunction

    function automatic bit coord_in_target(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        return (int'(x) < clamp_side(size_reg[nnbs_pkg::REG_TARGET_WIDTH])) &&
               (int'(y) < clamp_side(size_reg[nnbs_pkg::REG_TARGET_HEIGHT]));
    endfunction

    // Raster index of the source pixel nearest to a target coordinate.
    function automatic int nearest_source_index(logic [COORD_W-1:0] x,
                                                logic [COORD_W-1:0] y);
        int sw;
        int sx;
        int sy;
        sw = clamp_side(size_reg[nnbs_pkg::REG_SOURCE_WIDTH]);
        sx = (int'(x) * sw) / clamp_side(size_reg[nnbs_pkg::REG_TARGET_WIDTH]);
        sy = (int'(y) * clamp_side(size_reg[nnbs_pkg::REG_SOURCE_HEIGHT]))
             / clamp_side(size_reg[nnbs_pkg::REG_TARGET_HEIGHT]);
        return sy * sw + sx;
    endfunction

    function automatic mark_result_t predict_mark(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y);
        mark_result_t r;
        int idx;
        r.mark_value   = nnbs_pkg::MARK_OFF;
        r.out_of_range = 1'b0;
        if (!coord_in_target(x, y)) begin
            r.out_of_range = 1'b1;
        end else begin
            idx = nearest_source_index(x, y);
            if (idx < FRAME_DEPTH && frame_shadow[idx] > nnbs_pkg::THRESHOLD) begin
                r.mark_value = nnbs_pkg::MARK_ON;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic queue_load(int addr, int pix);
        scaler_beat_t b;
        b.action       = nnbs_pkg::ACT_LOAD;
        b.load_address = ADDR_W'(addr);
        b.load_pixel   = PIXEL_W'(pix);
        b.target_x     = COORD_W'($urandom);
        b.target_y     = COORD_W'($urandom);
        loaded_map[addr] = 1'b1;
        pending_beats.push_back(b);
    endtask

    // A fetch whose mapped pixel was never loaded gets a load in front of it.
    task automatic queue_fetch(int x, int y);
        scaler_beat_t b;
        int idx;
        if (coord_in_target(COORD_W'(x), COORD_W'(y))) begin
            idx = nearest_source_index(COORD_W'(x), COORD_W'(y));
            if (!loaded_map[idx]) begin
                queue_load(idx, $urandom_range(255));
            end
        end
        b.action       = nnbs_pkg::ACT_FETCH;
        b.load_address = ADDR_W'($urandom);
        b.load_pixel   = PIXEL_W'($urandom);
        b.target_x     = COORD_W'(x);
        b.target_y     = COORD_W'(y);
        pending_beats.push_back(b);
    endtask

    // Mostly in-range fetches, some loads, some fetches anywhere in the plane.
    task automatic queue_random_mix(int count);
        int n;
        int pick;
        int tw;
        int th;
        int area;
        tw   = clamp_side(size_reg[nnbs_pkg::REG_TARGET_WIDTH]);
        th   = clamp_side(size_reg[nnbs_pkg::REG_TARGET_HEIGHT]);
        area = clamp_side(size_reg[nnbs_pkg::REG_SOURCE_WIDTH])
               * clamp_side(size_reg[nnbs_pkg::REG_SOURCE_HEIGHT]);
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                if (pick < 12) begin
                    queue_load($urandom_range(area - 1), $urandom_range(255));
                end else begin
                    queue_load($urandom_range(FRAME_DEPTH - 1), $urandom_range(255));
                end
            end else if (pick < 88) begin
                queue_fetch($urandom_range(tw - 1), $urandom_range(th - 1));
            end else begin
                queue_fetch($urandom_range(255), $urandom_range(255));
            end
        end
    endtask

    // Wait until every beat is accepted and every result is back, then let
    // the block finish any trailing load.
    task automatic drain_and_settle();
        while (pending_beats.size() != 0 || beat_held || awaited_marks.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        size_reg[idx] = val;
    endtask

    // New sizes and a new idling pattern, written only while the block is idle.
    task automatic start_phase(logic [SIZE_W-1:0] sw, logic [SIZE_W-1:0] sh,
                               logic [SIZE_W-1:0] tw, logic [SIZE_W-1:0] th);
        drain_and_settle();
        write_reg(nnbs_pkg::REG_SOURCE_WIDTH, sw);
        write_reg(nnbs_pkg::REG_SOURCE_HEIGHT, sh);
        write_reg(nnbs_pkg::REG_TARGET_WIDTH, tw);
        write_reg(nnbs_pkg::REG_TARGET_HEIGHT, th);
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (phase_index < 4) begin
            send_gap_pct   = 22;
            recv_stall_pct = 56;
        end else if (phase_index < 7) begin
            send_gap_pct   = 56;
            recv_stall_pct = 22;
        end else begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
        end
        phase_index++;
    endtask

    // Driver: presents the next beat and holds it until it is taken.
    always @(negedge aclk) begin
        if (!beat_held) begin
            if (aresetn && pending_beats.size() != 0 &&
                $urandom_range(99) >= send_gap_pct) begin
                beat_on_bus = pending_beats.pop_front();
                beat_held   = 1'b1;
                s_valid        <= 1'b1;
                s_action       <= beat_on_bus.action;
                s_load_address <= beat_on_bus.load_address;
                s_load_pixel   <= beat_on_bus.load_pixel;
                s_target_x     <= beat_on_bus.target_x;
                s_target_y     <= beat_on_bus.target_y;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predicts on each accepted input beat and checks each result beat.
    always @(posedge aclk) begin
        mark_result_t want;
        if (aresetn && s_valid && s_ready) begin
            if (beat_on_bus.action == nnbs_pkg::ACT_LOAD) begin
                frame_shadow[beat_on_bus.load_address] = beat_on_bus.load_pixel;
            end else begin
                awaited_marks.push_back(predict_mark(beat_on_bus.target_x,
                                                     beat_on_bus.target_y));
            end
            beat_held = 1'b0;
        end
        if (aresetn && m_valid && m_ready) begin
            if (awaited_marks.size() == 0) begin
                report_mismatch($sformatf("result beat with none expected: mark %0d flag %0b",
                                          m_mark_value, m_out_of_range));
            end else begin
                want = awaited_marks.pop_front();
                if (m_mark_value !== want.mark_value) begin
                    report_mismatch($sformatf("mark_value %0d, expected %0d",
                                              m_mark_value, want.mark_value));
                end
                if (m_out_of_range !== want.out_of_range) begin
                    report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                              m_out_of_range, want.out_of_range));
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
    end

    // Watchdog on a stalled handshake.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(negedge aclk);
        end
        $display("nearest_neighbor_binarize_scaler: mismatch");
        $finish;
    end

    initial begin
        size_reg[nnbs_pkg::REG_SOURCE_WIDTH]  = nnbs_pkg::SOURCE_WIDTH_RST;
        size_reg[nnbs_pkg::REG_SOURCE_HEIGHT] = nnbs_pkg::SOURCE_HEIGHT_RST;
        size_reg[nnbs_pkg::REG_TARGET_WIDTH]  = nnbs_pkg::TARGET_WIDTH_RST;
        size_reg[nnbs_pkg::REG_TARGET_HEIGHT] = nnbs_pkg::TARGET_HEIGHT_RST;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset sizes: threshold edges, a few mappings, highest address,
        // coordinates outside the target on each axis.
        start_phase(nnbs_pkg::SOURCE_WIDTH_RST, nnbs_pkg::SOURCE_HEIGHT_RST,
                    nnbs_pkg::TARGET_WIDTH_RST, nnbs_pkg::TARGET_HEIGHT_RST);
        queue_load(0, 129);
        queue_fetch(0, 0);
        queue_load(nearest_source_index(8'd63, 8'd63), 128);
        queue_fetch(63, 63);
        queue_load(nearest_source_index(8'd1, 8'd0), 0);
        queue_fetch(1, 0);
        queue_load(nearest_source_index(8'd0, 8'd1), 255);
        queue_fetch(0, 1);
        queue_load(16'hFFFF, 255);
        queue_load(16'h5AA5, 8'hA5);
        queue_load(16'hA55A, 8'h5A);
        queue_fetch(64, 0);
        queue_fetch(0, 64);
        queue_fetch(255, 255);

        // Largest sizes: the mapping is the identity.
        start_phase(9'd256, 9'd256, 9'd256, 9'd256);
        queue_fetch(255, 255);
        queue_fetch(0, 0);
        queue_load(nearest_source_index(8'd128, 8'd127), 200);
        queue_fetch(128, 127);

        // Smallest sizes: one pixel in, one pixel out.
        start_phase(9'd1, 9'd1, 9'd1, 9'd1);
        queue_fetch(0, 0);
        queue_fetch(1, 0);
        queue_fetch(0, 1);
        queue_load(0, 128);
        queue_fetch(0, 0);

        start_phase(SIZE_W'($urandom_range(256, 1)), SIZE_W'($urandom_range(256, 1)),
                    SIZE_W'($urandom_range(256, 1)), SIZE_W'($urandom_range(256, 1)));
        queue_random_mix(RANDOM_BEATS);

        // Register values outside the legal range are clamped.
        start_phase(9'd0, 9'd511, 9'd300, 9'd0);
        queue_random_mix(RANDOM_BEATS);

        start_phase(SIZE_W'($urandom_range(16, 1)), SIZE_W'($urandom_range(16, 1)),
                    SIZE_W'($urandom_range(16, 1)), SIZE_W'($urandom_range(16, 1)));
        queue_random_mix(RANDOM_BEATS);

        start_phase(9'd200, 9'd150, 9'd256, 9'd256);
        queue_random_mix(RANDOM_BEATS);

        start_phase(9'd16, 9'd16, 9'd256, 9'd256);
        queue_random_mix(RANDOM_BEATS);

        start_phase(SIZE_W'($urandom_range(511)), SIZE_W'($urandom_range(511)),
                    SIZE_W'($urandom_range(511)), SIZE_W'($urandom_range(511)));
        queue_random_mix(RANDOM_BEATS);

        drain_and_settle();
        if (mismatch_count == 0) begin
            $display("nearest_neighbor_binarize_scaler: match");
        end else begin
            $display("nearest_neighbor_binarize_scaler: mismatch");
        end
        $finish;
    end

endmodule
